@@ rtl/npcm_pkg.sv @@
// ----------------------------------------------------------------------------
// npcm_pkg
// shared types and codes for the nearest palette colour mapper
// ----------------------------------------------------------------------------
package npcm_pkg;

  // request kinds carried on the slave-side tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // fixed field widths of the stream payloads
  localparam int IDX_BITS  = 6;
  localparam int CFG_BITS  = 7;
  localparam int CH_OUT    = 8;
  localparam int TDATA_BITS = 32;

  // control that travels with each transaction along the cell chain
  typedef struct packed {
    logic valid;
    logic pixel;
    logic have;
  } ctrl_t;

endpackage

@@ rtl/npcm_cell.sv @@
// ----------------------------------------------------------------------------
// npcm_cell
// one palette slot: holds its entry, scores a passing pixel against it
// and forwards the running best to the next cell
// ----------------------------------------------------------------------------
module npcm_cell #(
  parameter int CB   = 8,
  parameter int IW   = 6,
  parameter int CELL = 0,
  localparam int DW  = 2*CB+2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [npcm_pkg::CFG_BITS-1:0]     palette_size,
  input  npcm_pkg::ctrl_t                   in_ctrl,
  input  logic [npcm_pkg::IDX_BITS-1:0]     in_idx,
  input  logic [3*CB-1:0]                   in_pix,
  input  logic [DW-1:0]                     in_bd,
  input  logic [IW-1:0]                     in_bi,
  input  logic [3*CB-1:0]                   in_bc,
  output npcm_pkg::ctrl_t                   out_ctrl,
  output logic [npcm_pkg::IDX_BITS-1:0]     out_idx,
  output logic [3*CB-1:0]                   out_pix,
  output logic [DW-1:0]                     out_bd,
  output logic [IW-1:0]                     out_bi,
  output logic [3*CB-1:0]                   out_bc
);

  logic [3*CB-1:0]  ent;
  logic [2*CB-1:0]  sq [3];
  logic             act;
  logic             wr;

  npcm_pkg::ctrl_t                 a_ctrl;
  logic [npcm_pkg::IDX_BITS-1:0]   a_idx;
  logic [3*CB-1:0]                 a_pix;
  logic [DW-1:0]                   a_bd;
  logic [IW-1:0]                   a_bi;
  logic [3*CB-1:0]                 a_bc;
  logic [3*CB-1:0]                 a_ent;
  logic [2*CB-1:0]                 a_sq [3];
  logic                            a_act;

  logic [DW-1:0]  sum;
  logic           take;

  assign act = (32'(palette_size) > 32'(CELL));
  assign wr  = adv && in_ctrl.valid && !in_ctrl.pixel && (32'(in_idx) == 32'(CELL));

  // entry store, no reset: undefined until loaded
  always_ff @(posedge clk) begin
    if (wr) begin
      ent <= in_pix;
    end
  end

  // per-channel squared difference
  always_comb begin
    logic [CB-1:0] pc, ec, dc;
    for (int c = 0; c < 3; c++) begin
      pc = in_pix[c*CB +: CB];
      ec = ent[c*CB +: CB];
      dc = (pc > ec) ? pc - ec : ec - pc;
      sq[c] = (2*CB)'(dc) * (2*CB)'(dc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl <= '0;
    end else if (adv) begin
      a_ctrl <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx <= in_idx;
      a_pix <= in_pix;
      a_bd  <= in_bd;
      a_bi  <= in_bi;
      a_bc  <= in_bc;
      a_ent <= ent;
      a_sq  <= sq;
      a_act <= act;
    end
  end

  // sum and compare, strict less keeps the lower index on a tie
  assign sum  = DW'(a_sq[0]) + DW'(a_sq[1]) + DW'(a_sq[2]);
  assign take = a_act && a_ctrl.pixel && (!a_ctrl.have || (sum < a_bd));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (adv) begin
      out_ctrl.valid <= a_ctrl.valid;
      out_ctrl.pixel <= a_ctrl.pixel;
      out_ctrl.have  <= a_ctrl.have || take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx <= a_idx;
      out_pix <= a_pix;
      out_bd  <= take ? sum : a_bd;
      out_bi  <= take ? IW'(CELL) : a_bi;
      out_bc  <= take ? a_ent : a_bc;
    end
  end

endmodule

@@ rtl/nearest_palette_color_map.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_map
// maps rgb pixels to the nearest loaded palette colour by squared distance
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: tuser selects a palette load or a pixel. a load
//   writes entry_index with the colour and gives no result transaction. a
//   pixel gives one result on m_axis: the nearest palette colour, its index
//   and found; ties go to the lowest index, an empty palette gives black
//   with found clear. cfg_valid/cfg_data write palette_size (always ready);
//   write it only while the block is idle.
//   structure: a chain of MAX_COLORS cells, one per palette slot. every
//   transaction walks the chain, two register stages per cell (squares,
//   then sum and compare), so loads and pixels stay in order.
//   throughput: one transaction per cycle while the receiver keeps up, set by the cell stage pitch.
//   when the receiver stalls the whole chain freezes and s_axis_tready
//   drops; the output register lets the chain move while it is being taken.
//   reset clears palette_size and the valid flags of the chain and output;
//   palette entries are not cleared and must be loaded before use.
module nearest_palette_color_map #(
  parameter int MAX_COLORS   = 64,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry_index[5:0], red[13:6], green[21:14], blue[29:22], zero pad
  input  logic [npcm_pkg::TDATA_BITS-1:0]     s_axis_tdata,
  // req_type[0]
  input  logic                                s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], chosen_index[29:24],
  // found[30], zero pad
  output logic [npcm_pkg::TDATA_BITS-1:0]     m_axis_tdata,
  // configuration: palette_size
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [npcm_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int CB = CHANNEL_BITS;
  localparam int IW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int DW = 2*CB+2;

  logic [npcm_pkg::CFG_BITS-1:0] palette_size;
  logic                          adv;

  // chain links, element 0 is the input side
  npcm_pkg::ctrl_t               c_ctrl [MAX_COLORS+1];
  logic [npcm_pkg::IDX_BITS-1:0] c_idx  [MAX_COLORS+1];
  logic [3*CB-1:0]               c_pix  [MAX_COLORS+1];
  logic [DW-1:0]                 c_bd   [MAX_COLORS+1];
  logic [IW-1:0]                 c_bi   [MAX_COLORS+1];
  logic [3*CB-1:0]               c_bc   [MAX_COLORS+1];

  logic                          out_valid;
  logic [npcm_pkg::TDATA_BITS-1:0] out_data;
  logic [npcm_pkg::TDATA_BITS-1:0] out_next;

  // chain moves when the output register is empty or being drained
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
    end else if (cfg_valid) begin
      palette_size <= cfg_data;
    end
  end

  // chain head: unpack the request, channels fitted to CHANNEL_BITS
  assign c_ctrl[0].valid = s_axis_tvalid;
  assign c_ctrl[0].pixel = (s_axis_tuser == npcm_pkg::REQ_PIXEL);
  assign c_ctrl[0].have  = 1'b0;
  assign c_idx[0]        = s_axis_tdata[5:0];
  assign c_bd[0]         = '0;
  assign c_bi[0]         = '0;
  assign c_bc[0]         = '0;

  always_comb begin
    logic [31:0] r32, g32, b32;
    r32 = 32'(s_axis_tdata[13:6]);
    g32 = 32'(s_axis_tdata[21:14]);
    b32 = 32'(s_axis_tdata[29:22]);
    c_pix[0] = {b32[CB-1:0], g32[CB-1:0], r32[CB-1:0]};
  end

  for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
    npcm_cell #(
      .CB   (CB),
      .IW   (IW),
      .CELL (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .palette_size (palette_size),
      .in_ctrl      (c_ctrl[i]),
      .in_idx       (c_idx[i]),
      .in_pix       (c_pix[i]),
      .in_bd        (c_bd[i]),
      .in_bi        (c_bi[i]),
      .in_bc        (c_bc[i]),
      .out_ctrl     (c_ctrl[i+1]),
      .out_idx      (c_idx[i+1]),
      .out_pix      (c_pix[i+1]),
      .out_bd       (c_bd[i+1]),
      .out_bi       (c_bi[i+1]),
      .out_bc       (c_bc[i+1])
    );
  end

  // chain tail: the best colour is zero until a cell takes the pixel,
  // so an empty palette already reads as black with index zero
  always_comb begin
    logic [31:0] r32, g32, b32, i32;
    r32 = 32'(c_bc[MAX_COLORS][0*CB +: CB]);
    g32 = 32'(c_bc[MAX_COLORS][1*CB +: CB]);
    b32 = 32'(c_bc[MAX_COLORS][2*CB +: CB]);
    i32 = 32'(c_bi[MAX_COLORS]);
    out_next = {1'b0, c_ctrl[MAX_COLORS].have, i32[npcm_pkg::IDX_BITS-1:0],
                b32[npcm_pkg::CH_OUT-1:0], g32[npcm_pkg::CH_OUT-1:0],
                r32[npcm_pkg::CH_OUT-1:0]};
  end

  // output register, loads pass through without a result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_ctrl[MAX_COLORS].valid && c_ctrl[MAX_COLORS].pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

@@ rtl/npcm_checker.sv @@
// ----------------------------------------------------------------------------
// npcm_checker
// port-level checks on the nearest palette colour mapper
// ----------------------------------------------------------------------------
module npcm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [npcm_pkg::TDATA_BITS-1:0] m_axis_tdata
);

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // an empty output slot never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // no match means black, index zero
  a_none_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[30] |-> m_axis_tdata[29:0] == 30'd0)
    else $error("result without match is not black");

endmodule

bind nearest_palette_color_map npcm_checker u_npcm_checker (.*);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for nearest_palette_color_map
// drives palette loads and pixels on the request stream, predicts the nearest
// palette colour for each accepted pixel and checks every result transaction
// in order, with random idling on both stream sides and one long output stall
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PALETTE_DEPTH = 64;
  // a transaction takes two stages per palette cell plus the output register
  localparam int CHAIN_LATENCY = 2 * PALETTE_DEPTH + 1;
  localparam int SETTLE_CYCLES = CHAIN_LATENCY + 16;
  localparam int RANDOM_ITEMS  = 1950;
  // no idling over the closing stretch of the random part
  localparam int CALM_ITEMS    = 300;
  localparam int LONG_HOLD     = 500;
  localparam int CYCLE_LIMIT   = 600000;

  // packed so that red lands in the lowest byte, as on both tdata buses
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  // result layout of m_axis_tdata[30:0]
  typedef struct packed {
    logic                          found;
    logic [npcm_pkg::IDX_BITS-1:0] index;
    colour_t                       colour;
  } mapping_t;

  // palette copy, size register and the queue of pending pixel mappings
  class palette_scoreboard;
    colour_t     palette [PALETTE_DEPTH];
    int unsigned palette_size;
    mapping_t    expected_maps [$];
    int unsigned errors;

    // loads update the palette copy, pixels queue their nearest entry
    function void note_request(logic kind, logic [npcm_pkg::IDX_BITS-1:0] slot,
                               colour_t c);
      mapping_t    m;
      int unsigned used;
      int unsigned sq_dist;
      int unsigned best_dist;
      int          dr;
      int          dg;
      int          db;
      if (kind == npcm_pkg::REQ_LOAD) begin
        palette[slot] = c;
        return;
      end
      used = (palette_size > PALETTE_DEPTH) ? PALETTE_DEPTH : palette_size;
      m = '0;
      best_dist = 0;
      for (int i = 0; i < used; i++) begin
        dr = int'(c.red) - int'(palette[i].red);
        dg = int'(c.green) - int'(palette[i].green);
        db = int'(c.blue) - int'(palette[i].blue);
        sq_dist = dr * dr + dg * dg + db * db;
        // strict compare keeps the lowest index on a tie
        if (!m.found || sq_dist < best_dist) begin
          m.found = 1'b1;
          m.index = npcm_pkg::IDX_BITS'(i);
          m.colour = palette[i];
          best_dist = sq_dist;
        end
      end
      expected_maps.insert(expected_maps.size(), m);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_mapping(mapping_t got);
      mapping_t want;
      if (expected_maps.size() == 0) begin
        $display("%0t: result with no pixel waiting, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_maps.pop_front();
      compare_field("out_red", want.colour.red, got.colour.red);
      compare_field("out_green", want.colour.green, got.colour.green);
      compare_field("out_blue", want.colour.blue, got.colour.blue);
      compare_field("chosen_index", 8'(want.index), 8'(got.index));
      compare_field("found", 8'(want.found), 8'(got.found));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [npcm_pkg::TDATA_BITS-1:0] s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [npcm_pkg::TDATA_BITS-1:0] m_axis_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [npcm_pkg::CFG_BITS-1:0]   cfg_data;

  palette_scoreboard sb = new;
  int unsigned       cycle_count = 0;
  int unsigned       sent_items = 0;
  // idling switches for each side, and the request for one long output stall
  bit                tx_idle_on = 1'b1;
  bit                rx_idle_on = 1'b1;
  bit                long_hold = 1'b0;

  nearest_palette_color_map DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // monitor: every handshake is sampled at the rising edge, inputs having
  // settled at the falling edge before
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_palette_color_map: mismatch");
      $finish;
    end else if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser, s_axis_tdata[5:0], colour_t'(s_axis_tdata[29:6]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_mapping(mapping_t'(m_axis_tdata[30:0]));
      end
      if (cfg_valid && cfg_ready) begin
        sb.palette_size = 32'(cfg_data);
      end
    end
  end

  // receiver: ready most of the time, random stall bursts, and on request one
  // long stall that lets the cell chain fill and push back on the input
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic colour_t rgb(int r, int g, int b);
    return {8'(b), 8'(g), 8'(r)};
  endfunction

  // channel values lean towards the extremes and a coarse grid, so that
  // ties between palette entries come up often
  function automatic logic [7:0] pick_channel();
    int v;
    case ($urandom_range(0, 3))
      0: begin
        return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      end
      1: begin
        v = $urandom_range(0, 4) * 64;
        return (v > 255) ? 8'hff : 8'(v);
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  function automatic colour_t random_colour();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] ch);
    int v;
    v = int'(ch) + int'($urandom_range(0, 8)) - 4;
    return (v < 0) ? 8'h00 : (v > 255) ? 8'hff : 8'(v);
  endfunction

  // pixels either fully random or close to (often on) a palette colour
  function automatic colour_t pixel_colour();
    colour_t base;
    if ($urandom_range(0, 1) == 0) begin
      return random_colour();
    end
    base = sb.palette[npcm_pkg::IDX_BITS'($urandom_range(0, PALETTE_DEPTH - 1))];
    if ($urandom_range(0, 2) == 0) begin
      return base;
    end
    return {nudge(base.blue), nudge(base.green), nudge(base.red)};
  endfunction

  // offer one request and hold it until taken, then maybe leave a gap
  task automatic send_request(logic kind, logic [npcm_pkg::IDX_BITS-1:0] slot,
                              colour_t c);
    int unsigned gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, c, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering, wait for every pixel result, then let trailing loads
  // run out of the chain
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_maps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // palette_size changes only with the block idle
  task automatic write_palette_size(logic [npcm_pkg::CFG_BITS-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mixed stream: roughly one load per three pixels, loads at random slots
  task automatic run_phase(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(npcm_pkg::REQ_LOAD,
                     npcm_pkg::IDX_BITS'($urandom_range(0, PALETTE_DEPTH - 1)),
                     random_colour());
      end else begin
        send_request(npcm_pkg::REQ_PIXEL,
                     npcm_pkg::IDX_BITS'($urandom_range(0, PALETTE_DEPTH - 1)),
                     pixel_colour());
      end
    end
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    int unsigned size;
    int unsigned phase_items;
    int          size_plan [$];

    size_plan = '{127, 64, 0, 1, 65, 2};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = npcm_pkg::REQ_LOAD;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty palette: black, index 0, found clear
    write_palette_size(7'd0);
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(0, 0, 0));
    send_request(npcm_pkg::REQ_PIXEL, 6'd63, rgb(255, 255, 255));

    // small palette with a duplicate of entry 0 and a mid grey; the top slot
    // is loaded too but stays outside the palette in use for now
    send_request(npcm_pkg::REQ_LOAD, 6'd0, rgb(0, 0, 0));
    send_request(npcm_pkg::REQ_LOAD, 6'd1, rgb(255, 255, 255));
    send_request(npcm_pkg::REQ_LOAD, 6'd2, rgb(0, 0, 0));
    send_request(npcm_pkg::REQ_LOAD, 6'd3, rgb(128, 128, 128));
    send_request(npcm_pkg::REQ_LOAD, 6'd4, rgb(10, 20, 30));
    send_request(npcm_pkg::REQ_LOAD, 6'd63, rgb(255, 0, 255));
    write_palette_size(7'd5);
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(0, 0, 0));        // exact tie of 0 and 2
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(255, 255, 255));
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(64, 64, 64));     // equidistant from 0 and 3
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(255, 0, 0));
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(10, 20, 30));
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(200, 200, 200));
    write_palette_size(7'd1);
    send_request(npcm_pkg::REQ_PIXEL, 6'd0, rgb(255, 255, 255));

    // fill every slot so that any palette size reads written entries only
    random_start = sent_items;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      send_request(npcm_pkg::REQ_LOAD, npcm_pkg::IDX_BITS'(i), random_colour());
    end

    phase = 0;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      if (sent_items - random_start > RANDOM_ITEMS - CALM_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (phase < size_plan.size()) begin
        size = size_plan[phase];
      end else if ($urandom_range(0, 2) == 0) begin
        size = PALETTE_DEPTH;
      end else begin
        size = $urandom_range(0, 127);
      end
      write_palette_size(npcm_pkg::CFG_BITS'(size));
      // full palette: stall the output long enough to back up the whole chain
      if (phase == 1) begin
        long_hold = 1'b1;
      end
      phase_items = $urandom_range(100, 200);
      if (phase_items > RANDOM_ITEMS - (sent_items - random_start)) begin
        phase_items = RANDOM_ITEMS - (sent_items - random_start);
      end
      run_phase(phase_items);
      phase++;
    end

    drain_results();
    if (sb.errors == 0 && sb.expected_maps.size() == 0) begin
      $display("nearest_palette_color_map: match");
    end else begin
      $display("nearest_palette_color_map: mismatch");
    end
    $finish;
  end

endmodule
